@@ hw/rtl/ptcl_pkg.sv @@
// Shared types and constants for the press timing code lock.
package ptcl_pkg;

  localparam int unsigned TimeW      = 32;
  localparam int unsigned StepW      = 5;
  localparam int unsigned BoundW     = 20;
  localparam int unsigned NumClasses = 4;
  localparam int unsigned CodeSlots  = 21;
  localparam int unsigned PatternW   = 2 * CodeSlots;
  localparam int unsigned CfgDataW   = PatternW;
  localparam int unsigned CfgIdxW    = 3;

  localparam logic [TimeW-1:0] NotifyGapMs  = TimeW'(10000);
  localparam logic [TimeW-1:0] ReallowGapMs = TimeW'(30000);
  localparam logic [2:0]       AttemptLimit = 3'd3;

  typedef enum logic [CfgIdxW-1:0] {
    CfgAnyWin      = 3'd0,
    CfgShortWin    = 3'd1,
    CfgLongWin     = 3'd2,
    CfgVeryLongWin = 3'd3,
    CfgCodePattern = 3'd4,
    CfgCodeLength  = 3'd5,
    CfgRingEnable  = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [BoundW-1:0] hi;
    logic [BoundW-1:0] lo;
  } win_t;

  typedef struct packed {
    win_t [NumClasses-1:0] win;
    logic [PatternW-1:0]   code_pattern;
    logic [StepW-1:0]      code_length;
    logic                  ringcode_enable;
  } cfg_t;

  typedef struct packed {
    logic             pin_level;
    logic [TimeW-1:0] time_ms;
  } in_item_t;

  typedef struct packed {
    logic             ring_bell;
    logic             notify_ring;
    logic             unlock_pulse;
    logic             unlock_refused;
    logic [1:0]       interval_class;
    logic [StepW-1:0] code_step;
    logic             unlock_allowed;
  } out_item_t;

  typedef struct packed {
    logic [NumClasses-1:0] hit;
    logic [1:0]            cls;
  } class_t;

endpackage

@@ hw/rtl/press_timing_code_lock.sv @@
// Top level: request registers, configuration registers and result register.
// The result register loads when free or drained. Throughput: one request
// per cycle unless output stalls; all work for an edge is one combinational
// pass from the input register to the result register, state updating in place.
// Repeated-level edges are consumed with no result. Reset (rst_ni low, async)
// clears both stages, returns the step counter to idle, re-arms the first-edge
// flag and the attempt guard, and loads the register defaults (ringcode on).
module press_timing_code_lock (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  ptcl_pkg::in_item_t               in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output ptcl_pkg::out_item_t              out_data_o,
  input  logic                             cfg_we_i,
  input  logic [ptcl_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [ptcl_pkg::CfgDataW-1:0]    cfg_wdata_i
);

  // request stage
  logic                 in_vld_q;
  ptcl_pkg::in_item_t   in_data_q;
  // result stage
  logic                 out_vld_q;
  ptcl_pkg::out_item_t  out_data_q;
  // configuration
  ptcl_pkg::cfg_t       cfg_q;

  logic                          proc_go, keep;
  logic [ptcl_pkg::TimeW-1:0]    interval;
  ptcl_pkg::class_t              cls;
  ptcl_pkg::out_item_t           result;

  // the held request moves on when the result slot is free or being drained;
  // a dropped edge moves on too but leaves the slot empty
  assign proc_go    = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || proc_go;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_data_q <= in_data_i;
    end
  end

  ptcl_class u_class (
    .cfg_i      (cfg_q),
    .interval_i (interval),
    .class_o    (cls)
  );

  ptcl_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (proc_go),
    .item_i     (in_data_q),
    .cfg_i      (cfg_q),
    .class_i    (cls),
    .interval_o (interval),
    .keep_o     (keep),
    .result_o   (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (proc_go) begin
      out_vld_q <= keep;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc_go) begin
      out_data_q <= result;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_data_q;

  // register writes; indexes past the list are ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{win: '0, code_pattern: '0, code_length: '0, ringcode_enable: 1'b1};
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ptcl_pkg::CfgAnyWin:      cfg_q.win[0] <= ptcl_pkg::win_t'(cfg_wdata_i[39:0]);
        ptcl_pkg::CfgShortWin:    cfg_q.win[1] <= ptcl_pkg::win_t'(cfg_wdata_i[39:0]);
        ptcl_pkg::CfgLongWin:     cfg_q.win[2] <= ptcl_pkg::win_t'(cfg_wdata_i[39:0]);
        ptcl_pkg::CfgVeryLongWin: cfg_q.win[3] <= ptcl_pkg::win_t'(cfg_wdata_i[39:0]);
        ptcl_pkg::CfgCodePattern: cfg_q.code_pattern <= cfg_wdata_i;
        ptcl_pkg::CfgCodeLength:
          cfg_q.code_length <= cfg_wdata_i[ptcl_pkg::StepW-1:0];
        ptcl_pkg::CfgRingEnable:  cfg_q.ringcode_enable <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

endmodule

@@ hw/rtl/ptcl_class.sv @@
// Interval window compare and class selection.
module ptcl_class (
  input  ptcl_pkg::cfg_t                  cfg_i,
  input  logic [ptcl_pkg::TimeW-1:0]      interval_i,
  output ptcl_pkg::class_t                class_o
);

  always_comb begin
    for (int i = 0; i < ptcl_pkg::NumClasses; i++) begin
      class_o.hit[i] =
        (interval_i >= ptcl_pkg::TimeW'(cfg_i.win[i].lo)) &&
        (interval_i <= ptcl_pkg::TimeW'(cfg_i.win[i].hi));
    end
    // longest matching class wins; the "any" window never names a class
    priority if (class_o.hit[3]) class_o.cls = 2'd3;
    else if (class_o.hit[2])    class_o.cls = 2'd2;
    else if (class_o.hit[1])    class_o.cls = 2'd1;
    else                        class_o.cls = 2'd0;
  end

endmodule

@@ hw/rtl/ptcl_seq.sv @@
// Edge filter, code step counter, ring timing and attempt guard.
module ptcl_seq (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          fire_i,
  input  ptcl_pkg::in_item_t            item_i,
  input  ptcl_pkg::cfg_t                cfg_i,
  input  ptcl_pkg::class_t              class_i,
  output logic [ptcl_pkg::TimeW-1:0]    interval_o,
  output logic                          keep_o,
  output ptcl_pkg::out_item_t           result_o
);

  logic                         first_q, prev_lvl_q, allow_q, allow_d;
  logic [1:0]                   att_q, att_d;
  logic [ptcl_pkg::StepW-1:0]   step_q, step_d;
  logic [ptcl_pkg::TimeW-1:0]   edge_time_q, ring_time_q;

  logic                         press, ok, do_ring, do_count, unlock, refused;
  logic [ptcl_pkg::StepW-1:0]   len, idx;
  logic [1:0]                   want;
  logic [2:0]                   cnt;
  logic [ptcl_pkg::TimeW-1:0]   ring_dt;

  assign interval_o = item_i.time_ms - edge_time_q;
  assign keep_o     = first_q || (item_i.pin_level != prev_lvl_q);
  assign press      = !item_i.pin_level;
  assign len        = (cfg_i.code_length > ptcl_pkg::StepW'(ptcl_pkg::CodeSlots)) ?
                      ptcl_pkg::StepW'(ptcl_pkg::CodeSlots) : cfg_i.code_length;
  assign idx        = step_q - ptcl_pkg::StepW'(1);
  assign want       = 2'(cfg_i.code_pattern >> {idx, 1'b0});
  assign ok         = class_i.hit[want] && allow_q;
  assign ring_dt    = item_i.time_ms - ring_time_q;

  always_comb begin
    step_d   = step_q;
    do_ring  = 1'b0;
    do_count = 1'b0;
    unlock   = 1'b0;
    refused  = 1'b0;
    if (step_q > len) begin
      step_d = '0;
    end else if (step_q == '0) begin
      if (press) begin
        step_d   = ptcl_pkg::StepW'(1);
        do_count = 1'b1;
      end
    end else if (!step_q[0]) begin
      // press step
      if (ok && press) begin
        step_d = step_q + ptcl_pkg::StepW'(1);
      end else begin
        step_d   = ptcl_pkg::StepW'(1);
        do_ring  = 1'b1;
        do_count = 1'b1;
      end
    end else if (step_q == ptcl_pkg::StepW'(1)) begin
      if (ok && !press) begin
        step_d = ptcl_pkg::StepW'(2);
      end else begin
        step_d  = '0;
        do_ring = 1'b1;
      end
    end else if (step_q == len) begin
      if (ok && !press) begin
        unlock  = cfg_i.ringcode_enable;
        refused = !cfg_i.ringcode_enable;
      end
      step_d = '0;
    end else begin
      step_d = (ok && !press) ? step_q + ptcl_pkg::StepW'(1) : '0;
    end

    // attempt guard: long pause clears the count, then it counts up to the limit
    cnt     = (interval_o > ptcl_pkg::ReallowGapMs) ? 3'd0 : {1'b0, att_q};
    cnt     = cnt + 3'd1;
    att_d   = att_q;
    allow_d = allow_q;
    if (do_count) begin
      if (cnt > ptcl_pkg::AttemptLimit) begin
        allow_d = 1'b0;
        att_d   = ptcl_pkg::AttemptLimit[1:0];
      end else begin
        allow_d = 1'b1;
        att_d   = cnt[1:0];
      end
    end
  end

  always_comb begin
    result_o.ring_bell      = do_ring;
    result_o.notify_ring    = do_ring && (ring_dt > ptcl_pkg::NotifyGapMs);
    result_o.unlock_pulse   = unlock;
    result_o.unlock_refused = refused;
    result_o.interval_class = class_i.cls;
    result_o.code_step      = step_d;
    result_o.unlock_allowed = allow_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q     <= 1'b1;
      prev_lvl_q  <= 1'b0;
      step_q      <= '0;
      att_q       <= '0;
      allow_q     <= 1'b1;
      edge_time_q <= '0;
      ring_time_q <= '0;
    end else if (fire_i && keep_o) begin
      first_q     <= 1'b0;
      prev_lvl_q  <= item_i.pin_level;
      step_q      <= step_d;
      att_q       <= att_d;
      allow_q     <= allow_d;
      edge_time_q <= item_i.time_ms;
      if (do_ring) begin
        ring_time_q <= item_i.time_ms;
      end
    end
  end

endmodule
